>>> rtl/core/wsp_pkg.sv
// Package with the types and constants shared by the WAV stream chunk parser files.
package wsp_pkg;

	localparam int unsigned HEADER_BYTES = 36;
	localparam logic [31:0] DATA_TAG = 32'h6461_7461;
	localparam logic [2:0] CHUNK_HDR_LAST = 3'd7;
	localparam logic [2:0] CHUNK_TAG_BYTES = 3'd4;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_CHUNK   = 3'd1,
		PH_SKIP    = 3'd2,
		PH_PAD     = 3'd3,
		PH_SAMPLES = 3'd4,
		PH_ERROR   = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_in_chunk;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic        sample_valid;
		logic [7:0]  sample_byte;
		logic        error;
		logic [31:0] sample_count;
	} out_item_t;

endpackage

>>> rtl/core/wsp_in_if.sv
// Valid/ready channel that carries stream bytes into the parser.
interface wsp_in_if import wsp_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/wsp_out_if.sv
// Valid/ready channel that carries parser results out of the block.
interface wsp_out_if import wsp_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/wav_stream_chunk_parser_top.sv
// The parser takes one byte beat per cycle and returns one result beat for each byte
// taken. The parse state is updated in the same cycle that a byte is accepted, so a
// byte may follow in every cycle; the result goes into an output register backed by a
// one-entry skid buffer, so input ready drops only while the skid buffer holds a beat,
// that is with two result beats waiting. The first HEADER_BYTES bytes are skipped, then
// chunk headers are read and non-data chunks (with their pad byte) skipped; bytes after
// the data chunk header are forwarded as samples until restart. A network chunk that
// ends inside the file header puts the parser in a sticky error state until restart.
module wav_stream_chunk_parser_top import wsp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	wsp_in_if.sink    bytes,
	wsp_out_if.source samples
);

	phase_t      phase_q;
	logic [7:0]  byte_cnt_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic [31:0] skip_q;
	logic [31:0] fwd_q;

	phase_t      cur_phase, nxt_phase;
	logic [7:0]  cur_cnt, nxt_cnt;
	logic [31:0] cur_tag, nxt_tag;
	logic [31:0] cur_len, nxt_len;
	logic [31:0] cur_skip, nxt_skip;
	logic [31:0] cur_fwd, nxt_fwd;
	logic [31:0] skip_dec;
	logic [31:0] len_upd;
	logic [31:0] tag_upd;
	logic [2:0]  hdr_idx;
	logic [1:0]  len_idx;
	logic [8:0]  cnt_inc;
	logic        fwd;
	logic        accept;
	out_item_t   res;

	out_item_t out_q;
	logic      out_valid_q;
	out_item_t skid_q;
	logic      skid_valid_q;

	assign accept = bytes.valid && bytes.ready;

	always_comb begin
		// A restart beat is parsed as if the block had just left reset.
		if (bytes.payload.restart) begin
			cur_phase = PH_HEADER;
			cur_cnt   = '0;
			cur_tag   = '0;
			cur_len   = '0;
			cur_skip  = '0;
			cur_fwd   = '0;
		end else begin
			cur_phase = phase_q;
			cur_cnt   = byte_cnt_q;
			cur_tag   = tag_q;
			cur_len   = len_q;
			cur_skip  = skip_q;
			cur_fwd   = fwd_q;
		end

		nxt_phase = cur_phase;
		nxt_cnt   = cur_cnt;
		nxt_tag   = cur_tag;
		nxt_len   = cur_len;
		nxt_skip  = cur_skip;
		nxt_fwd   = cur_fwd;
		fwd       = 1'b0;

		cnt_inc  = {1'b0, cur_cnt} + 9'd1;
		hdr_idx  = cur_cnt[2:0];
		len_idx  = hdr_idx[1:0];
		tag_upd  = {cur_tag[23:0], bytes.payload.in_byte};
		len_upd  = cur_len | ({24'd0, bytes.payload.in_byte} << {len_idx, 3'd0});
		skip_dec = cur_skip - 32'd1;

		case (cur_phase)
			PH_HEADER: begin
				if (cnt_inc >= 9'(HEADER_BYTES)) begin
					nxt_phase = PH_CHUNK;
					nxt_cnt   = '0;
					nxt_tag   = '0;
					nxt_len   = '0;
				end else if (bytes.payload.last_in_chunk) begin
					nxt_phase = PH_ERROR;
				end else begin
					nxt_cnt = cnt_inc[7:0];
				end
			end
			PH_CHUNK: begin
				if (hdr_idx < CHUNK_TAG_BYTES) begin
					nxt_tag = tag_upd;
				end else begin
					nxt_len = len_upd;
				end
				if (hdr_idx == CHUNK_HDR_LAST) begin
					nxt_cnt = '0;
					if (cur_tag == DATA_TAG) begin
						nxt_phase = PH_SAMPLES;
					end else if (len_upd == '0) begin
						nxt_tag = '0;
					end else begin
						nxt_skip  = len_upd;
						nxt_phase = PH_SKIP;
					end
				end else begin
					nxt_cnt = {5'd0, hdr_idx + 3'd1};
				end
			end
			PH_SKIP: begin
				nxt_skip = skip_dec;
				if (skip_dec == '0) begin
					// RIFF pads an odd-length chunk with one byte.
					if (cur_len[0]) begin
						nxt_phase = PH_PAD;
					end else begin
						nxt_phase = PH_CHUNK;
						nxt_tag   = '0;
						nxt_len   = '0;
					end
				end
			end
			PH_PAD: begin
				nxt_phase = PH_CHUNK;
				nxt_tag   = '0;
				nxt_len   = '0;
			end
			PH_SAMPLES: begin
				fwd     = 1'b1;
				nxt_fwd = cur_fwd + 32'd1;
			end
			default: begin
			end
		endcase

		res.sample_valid = fwd;
		res.sample_byte  = fwd ? bytes.payload.in_byte : 8'd0;
		res.error        = (nxt_phase == PH_ERROR);
		res.sample_count = nxt_fwd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			byte_cnt_q <= '0;
			tag_q      <= '0;
			len_q      <= '0;
			skip_q     <= '0;
			fwd_q      <= '0;
		end else if (accept) begin
			phase_q    <= nxt_phase;
			byte_cnt_q <= nxt_cnt;
			tag_q      <= nxt_tag;
			len_q      <= nxt_len;
			skip_q     <= nxt_skip;
			fwd_q      <= nxt_fwd;
		end
	end

	assign bytes.ready     = !skid_valid_q;
	assign samples.valid   = out_valid_q;
	assign samples.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (samples.ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid buffer holds a beat while the output register is empty");

	a_zero_unforwarded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.sample_valid |-> out_q.sample_byte == 8'd0)
		else $error("non-sample result carries a non-zero byte");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !bytes.payload.restart && phase_q == PH_SAMPLES
		|=> fwd_q == $past(fwd_q) + 32'd1)
		else $error("sample count did not advance on a forwarded byte");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR && !(accept && bytes.payload.restart) |=> phase_q == PH_ERROR)
		else $error("error state left without restart");

endmodule
